[hdl/msam_pkg.sv]
package msam_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_DAILY = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] DRW_CLOSED_IDLE = 2'd0;
    localparam logic [1:0] DRW_OPEN_IDLE   = 2'd1;
    localparam logic [1:0] MODE_DAILY      = 2'd1;

    localparam logic REQ_OPEN  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    localparam int ENTRY_W = 33;

    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [3:0] open_hour;
        logic [5:0] open_minute;
        logic [1:0] open_half;
        logic [3:0] close_hour;
        logic [5:0] close_minute;
        logic [1:0] close_half;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_EMIT
    } state_t;

endpackage

[hdl/msam_ram.sv]
module msam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/meal_schedule_alarm_matcher_unit.sv]
// Meal schedule alarm matcher.
// Command channel: an item is taken at a rising edge with start high and busy
// low. Operation write stores one schedule entry (drawer, meal), operation
// daily sets a drawer's daily flag; neither raises busy.
// A check item with closed-idle or open-idle status raises busy, reads the
// drawer's MEALS entries from the schedule RAM one per cycle (one RAM read
// port with registered read data), then sends its requests in meal order.
// Result channel: result_strobe marks each request for exactly one cycle;
// last is high on the final request of a check. The receiver cannot stall.
// A check walks every entry of the drawer, then drains the last compare;
// a check without matches ends after the drain, others emit their requests.
// Checks with any other status, unknown operations, out-of-range drawers
// and writes to out-of-range meals are taken and give nothing.
// Reset clears control state and flags at once: per-entry valid flags make
// unwritten schedule entries read as zero; all drawers start in dated mode.
module meal_schedule_alarm_matcher_unit #(
    parameter int DRAWERS = 4,
    parameter int MEALS   = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [1:0] drawer,
    input  logic [2:0] meal,
    input  logic [4:0] day,
    input  logic [3:0] month,
    input  logic [3:0] hour_a,
    input  logic [5:0] minute_a,
    input  logic [1:0] ampm_a,
    input  logic [3:0] hour_b,
    input  logic [5:0] minute_b,
    input  logic [1:0] ampm_b,
    input  logic [1:0] status_or_mode,
    output logic       result_strobe,
    output logic [1:0] target_drawer,
    output logic [2:0] matched_meal,
    output logic       request,
    output logic       last
);

    import msam_pkg::*;

    localparam int DEPTH = DRAWERS * MEALS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int MW    = MEALS > 1 ? $clog2(MEALS) : 1;
    localparam int DW    = DRAWERS > 1 ? $clog2(DRAWERS) : 1;

    state_t state_reg, state_next;

    logic [DEPTH-1:0]   valid_reg;
    logic [DRAWERS-1:0] daily_reg;

    logic [AW-1:0] addr_reg, addr_next;
    logic [MW-1:0] walk_meal_reg, walk_meal_next;
    logic          cmp_vld_reg;
    logic [MW-1:0] cmp_meal_reg;
    logic          ent_vld_reg;

    logic [1:0] drawer_reg;
    logic [4:0] day_reg;
    logic [3:0] month_reg;
    logic [3:0] hour_reg;
    logic [5:0] minute_reg;
    logic [1:0] half_reg;
    logic       is_open_reg;
    logic       is_daily_reg;

    logic [MEALS-1:0] hits_reg, hits_next;

    logic       strobe_reg, strobe_next;
    logic [2:0] meal_out_reg, meal_out_next;
    logic       last_reg, last_next;

    logic          accept, in_range, do_write, do_daily, do_check;
    logic [DW-1:0] drw_idx;
    logic [AW-1:0] waddr, base_addr;
    logic          re;
    logic [ENTRY_W-1:0] rdata;
    entry_t        wentry, ent;
    logic          date_ok, open_eq, close_eq, hit;
    logic [MW-1:0] sel;
    logic [MEALS-1:0] remaining;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = int'(drawer) < DRAWERS;
    assign drw_idx  = DW'(drawer);
    assign do_write = accept && in_range && (operation == OP_WRITE) && (int'(meal) < MEALS);
    assign do_daily = accept && in_range && (operation == OP_DAILY);
    assign do_check = accept && in_range && (operation == OP_CHECK)
                      && (status_or_mode == DRW_CLOSED_IDLE || status_or_mode == DRW_OPEN_IDLE);

    assign waddr     = AW'(int'(drawer) * MEALS + int'(meal));
    assign base_addr = AW'(int'(drawer) * MEALS);

    assign wentry = '{day: day, month: month,
                      open_hour: hour_a, open_minute: minute_a, open_half: ampm_a,
                      close_hour: hour_b, close_minute: minute_b, close_half: ampm_b};

    assign re = (state_reg == S_WALK);

    msam_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (waddr),
        .wdata (wentry),
        .re    (re),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign ent      = ent_vld_reg ? entry_t'(rdata) : '0;
    assign date_ok  = is_daily_reg || (ent.day == day_reg && ent.month == month_reg);
    assign open_eq  = ent.open_hour == hour_reg && ent.open_minute == minute_reg
                      && ent.open_half == half_reg;
    assign close_eq = ent.close_hour == hour_reg && ent.close_minute == minute_reg
                      && ent.close_half == half_reg;
    assign hit      = cmp_vld_reg && date_ok && (is_open_reg ? close_eq : open_eq);

    always_comb
    begin
        sel = '0;
        for (int i = MEALS - 1; i >= 0; i--)
        begin
            if (hits_reg[i])
            begin
                sel = MW'(i);
            end
        end
    end

    assign remaining = hits_reg & ~(MEALS'(1) << sel);

    always_comb
    begin
        hits_next = hits_reg;
        if (state_reg == S_EMIT)
        begin
            hits_next = remaining;
        end
        else if (hit)
        begin
            hits_next = hits_reg | (MEALS'(1) << cmp_meal_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (do_check)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (int'(walk_meal_reg) == MEALS - 1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (hits_next != '0) ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (remaining == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and walk control
    always_comb
    begin
        addr_next      = addr_reg;
        walk_meal_next = walk_meal_reg;
        strobe_next    = 1'b0;
        meal_out_next  = meal_out_reg;
        last_next      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                addr_next      = base_addr;
                walk_meal_next = '0;
            end
            S_WALK:
            begin
                addr_next      = addr_reg + AW'(1);
                walk_meal_next = walk_meal_reg + MW'(1);
            end
            S_EMIT:
            begin
                strobe_next   = 1'b1;
                meal_out_next = 3'(sel);
                last_next     = (remaining == '0);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            daily_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            hits_reg    <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= re;
            hits_reg    <= (state_reg == S_IDLE) ? '0 : hits_next;
            strobe_reg  <= strobe_next;
            if (do_write)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (do_daily)
            begin
                daily_reg[drw_idx] <= (status_or_mode == MODE_DAILY);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        walk_meal_reg <= walk_meal_next;
        cmp_meal_reg  <= walk_meal_reg;
        ent_vld_reg   <= valid_reg[addr_reg];
        meal_out_reg  <= meal_out_next;
        last_reg      <= last_next;
        if (do_check)
        begin
            drawer_reg   <= drawer;
            day_reg      <= day;
            month_reg    <= month;
            hour_reg     <= hour_a;
            minute_reg   <= minute_a;
            half_reg     <= ampm_a;
            is_open_reg  <= (status_or_mode == DRW_OPEN_IDLE);
            is_daily_reg <= daily_reg[drw_idx];
        end
    end

    assign result_strobe = strobe_reg;
    assign target_drawer = drawer_reg;
    assign matched_meal  = meal_out_reg;
    assign request       = is_open_reg ? REQ_CLOSE : REQ_OPEN;
    assign last          = last_reg;

endmodule

[hdl/msam_checker.sv]
module msam_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       result_strobe,
    input logic [1:0] target_drawer,
    input logic       last
);

    import msam_pkg::*;

    // results only come out of a check that held busy
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without a running check");

    // requests of one check come back to back
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |=> result_strobe)
        else $error("gap inside a result burst");

    a_burst_drawer: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |=> target_drawer == $past(target_drawer))
        else $error("drawer changed inside a result burst");

    a_busy_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && operation == OP_CHECK))
        else $error("busy raised by a non-check item");

endmodule

bind meal_schedule_alarm_matcher_unit msam_checker u_msam_checker (.*);
